FILE: src/tpc_pkg.sv
// shared constants and codes for the triangle plane clipper
package tpc_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int CSR_IDX_W     = 8;
   localparam int COORDS        = 6;

   localparam logic signed [31:0] NORMAL_X_RST = 32'sh0000_0000;
   localparam logic signed [31:0] NORMAL_Y_RST = 32'sh0000_0000;
   localparam logic signed [31:0] NORMAL_Z_RST = 32'sh0001_0000;
   localparam logic signed [31:0] OFFSET_RST   = 32'sh0000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_NORMAL_X = 8'd0,
      REG_NORMAL_Y = 8'd1,
      REG_NORMAL_Z = 8'd2,
      REG_OFFSET   = 8'd3
   } reg_idx_type;

   // where an emitted vertex comes from
   typedef enum logic [2:0] {
      SRC_V0 = 3'd0,
      SRC_V1 = 3'd1,
      SRC_V2 = 3'd2,
      SRC_X0 = 3'd3,
      SRC_X1 = 3'd4
   } src_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DMUL,
      ST_DACC,
      ST_CLASS,
      ST_DINIT,
      ST_DIV,
      ST_IMUL,
      ST_IACC
   } state_type;

   typedef struct packed {
      src_type    src;
      logic       tri_idx;
      logic       last;
   } slot_type;

endpackage

FILE: src/triangle_plane_clipper.sv
// triangle clipper against one plane, built around a shared multiplier and divider
//
//   channel  dir  handshake          payload
//   req_     in   req_valid/stall    one vertex per beat
//   rsp_     out  rsp_valid/stall    one emitted vertex per beat
//   csr_     in   csr_valid/ready    register index and write data
//
// vertices 1 and 2 are only captured; the third starts the nine plane products
// and the classify step, then, when the triangle crosses the plane, a restoring
// divide (one quotient bit a cycle) and six multiply/accumulate pairs for each
// crossing, and finally one output beat per cycle while the output is not stalled.
// these steps share the single 33x33 multiplier and the divider.
// reset is synchronous; it clears the sequencer, vertex count and plane registers.
// a stalled output beat holds; emission waits on it and req_stall stays high.
module triangle_plane_clipper
   import tpc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [31:0]   req_pos_x,
   input  logic signed [31:0]   req_pos_y,
   input  logic signed [31:0]   req_pos_z,
   input  logic signed [31:0]   req_tex_u,
   input  logic signed [31:0]   req_tex_v,
   input  logic signed [31:0]   req_tex_w,
   input  logic [31:0]          req_colour_tag,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_out_x,
   output logic signed [31:0]   rsp_out_y,
   output logic signed [31:0]   rsp_out_z,
   output logic signed [31:0]   rsp_out_u,
   output logic signed [31:0]   rsp_out_v,
   output logic signed [31:0]   rsp_out_w,
   output logic [31:0]          rsp_out_colour,
   output logic                 rsp_triangle_index,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   localparam int QW  = FRAC_BITS + 1;
   localparam int BCW = $clog2(FRAC_BITS);

   state_type          state_ff, state_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic signed [31:0] held_ff [3][COORDS];
   logic signed [31:0] held_in [3][COORDS];
   logic [31:0]        colour_ff, colour_in;
   logic signed [31:0] norm_ff [3];
   logic signed [31:0] norm_in [3];
   logic signed [31:0] offs_ff, offs_in;
   logic [1:0]         vi_ff, vi_in;
   logic [2:0]         cidx_ff, cidx_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] dist_ff [3];
   logic signed [63:0] dist_in [3];
   logic signed [65:0] prod_ff, prod_in;
   logic [2:0]         ins_ff, ins_in;
   logic               xk_ff, xk_in;
   logic [QW-1:0]      q_ff, q_in;
   logic [63:0]        r_ff, r_in;
   logic [63:0]        den_ff, den_in;
   logic [BCW-1:0]     bc_ff, bc_in;
   logic signed [31:0] cross_ff [2][COORDS];
   logic signed [31:0] cross_in [2][COORDS];
   logic [2:0]         slot_ff, slot_in;
   logic               emit_ff, emit_in;
   logic               rv_ff, rv_in;
   logic signed [31:0] ov_ff [COORDS];
   logic signed [31:0] ov_in [COORDS];
   logic               otri_ff, otri_in;
   logic               olast_ff, olast_in;
   logic [31:0]        ocol_ff, ocol_in;

   // nth set (or clear) bit position of a three-bit mask
   function automatic logic [1:0] pick(input logic [2:0] m, input logic want,
                                       input logic nth);
      logic [1:0] hits;
      logic [1:0] res;
      hits = 2'd0;
      res  = 2'd0;
      for (int i = 0; i < 3; i++) begin
         if (m[i] == want) begin
            if (hits == {1'b0, nth}) begin
               res = 2'(i);
            end
            hits = hits + 2'd1;
         end
      end
      return res;
   endfunction

   function automatic slot_type slot_of(input logic [1:0] ni, input logic [2:0] k,
                                        input logic [1:0] ia, input logic [1:0] ib);
      slot_type s;
      s = '{src: SRC_V0, tri_idx: 1'b0, last: 1'b0};
      case (ni)
         2'd3: begin
            s.src  = src_type'(k);
            s.last = (k == 3'd2);
         end
         2'd1: begin
            case (k)
               3'd0:    s.src = src_type'({1'b0, ia});
               3'd1:    s.src = SRC_X0;
               default: begin
                  s.src  = SRC_X1;
                  s.last = 1'b1;
               end
            endcase
         end
         default: begin
            case (k)
               3'd0:    s.src = src_type'({1'b0, ia});
               3'd1:    s.src = src_type'({1'b0, ib});
               3'd2:    s.src = SRC_X0;
               3'd3: begin
                  s.src     = src_type'({1'b0, ib});
                  s.tri_idx = 1'b1;
               end
               3'd4: begin
                  s.src     = SRC_X0;
                  s.tri_idx = 1'b1;
               end
               default: begin
                  s.src     = SRC_X1;
                  s.tri_idx = 1'b1;
                  s.last    = 1'b1;
               end
            endcase
         end
      endcase
      return s;
   endfunction

   logic [1:0]          ni, ia, ib, o0, o1, s_idx, e_idx;
   logic signed [32:0]  mul_a, mul_b;
   logic signed [65:0]  prod_sh;
   logic signed [32:0]  diff;
   logic signed [34:0]  isum;
   logic [63:0]         r2;
   slot_type            slot;
   logic                take;
   logic signed [31:0]  src_val [COORDS];

   assign ni = 2'(ins_ff[0]) + 2'(ins_ff[1]) + 2'(ins_ff[2]);
   assign ia = pick(ins_ff, 1'b1, 1'b0);
   assign ib = pick(ins_ff, 1'b1, 1'b1);
   assign o0 = pick(ins_ff, 1'b0, 1'b0);
   assign o1 = pick(ins_ff, 1'b0, 1'b1);
   assign s_idx = (xk_ff && ni == 2'd2) ? ib : ia;
   assign e_idx = (xk_ff && ni == 2'd1) ? o1 : o0;
   assign prod_sh = prod_ff >>> FRAC_BITS;
   assign diff = {held_ff[e_idx][cidx_ff][31], held_ff[e_idx][cidx_ff]}
               - {held_ff[s_idx][cidx_ff][31], held_ff[s_idx][cidx_ff]};
   assign isum = {{3{held_ff[s_idx][cidx_ff][31]}}, held_ff[s_idx][cidx_ff]}
               + prod_sh[34:0];
   assign r2 = {r_ff[62:0], 1'b0};
   assign slot = slot_of(ni, slot_ff, ia, ib);
   assign take = !rv_ff || !rsp_stall;

   always_comb begin
      for (int c = 0; c < COORDS; c++) begin
         if (slot.src == SRC_X0 || slot.src == SRC_X1) begin
            src_val[c] = cross_ff[slot.src == SRC_X1][c];
         end else begin
            src_val[c] = held_ff[2'(slot.src)][c];
         end
      end
   end

   // shared multiplier operands
   always_comb begin
      if (state_ff == ST_IMUL) begin
         mul_a = diff;
         mul_b = 33'(q_ff);
      end else begin
         mul_a = {norm_ff[cidx_ff[1:0]][31], norm_ff[cidx_ff[1:0]]};
         mul_b = {held_ff[vi_ff][cidx_ff][31], held_ff[vi_ff][cidx_ff]};
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      held_in   = held_ff;
      colour_in = colour_ff;
      norm_in   = norm_ff;
      offs_in   = offs_ff;
      vi_in     = vi_ff;
      cidx_in   = cidx_ff;
      acc_in    = acc_ff;
      dist_in   = dist_ff;
      prod_in   = mul_a * mul_b;
      ins_in    = ins_ff;
      xk_in     = xk_ff;
      q_in      = q_ff;
      r_in      = r_ff;
      den_in    = den_ff;
      bc_in     = bc_ff;
      cross_in  = cross_ff;
      slot_in   = slot_ff;
      emit_in   = emit_ff;
      rv_in     = rv_ff && rsp_stall;
      ov_in     = ov_ff;
      otri_in   = otri_ff;
      olast_in  = olast_ff;
      ocol_in   = ocol_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_NORMAL_X: norm_in[0] = csr_wdata;
            REG_NORMAL_Y: norm_in[1] = csr_wdata;
            REG_NORMAL_Z: norm_in[2] = csr_wdata;
            REG_OFFSET:   offs_in    = csr_wdata;
            default:      ;
         endcase
      end

      // output beat loader runs alongside the idle state
      if (emit_ff && take) begin
         rv_in    = 1'b1;
         ov_in    = src_val;
         otri_in  = slot.tri_idx;
         olast_in = slot.last;
         ocol_in  = colour_ff;
         slot_in  = slot_ff + 3'd1;
         if (slot.last) begin
            emit_in = 1'b0;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !emit_ff) begin
               held_in[cnt_ff][0] = req_pos_x;
               held_in[cnt_ff][1] = req_pos_y;
               held_in[cnt_ff][2] = req_pos_z;
               held_in[cnt_ff][3] = req_tex_u;
               held_in[cnt_ff][4] = req_tex_v;
               held_in[cnt_ff][5] = req_tex_w;
               if (cnt_ff == 2'd0) begin
                  colour_in = req_colour_tag;
               end
               if (cnt_ff == 2'd2) begin
                  cnt_in   = 2'd0;
                  vi_in    = 2'd0;
                  cidx_in  = 3'd0;
                  state_in = ST_DMUL;
               end else begin
                  cnt_in = cnt_ff + 2'd1;
               end
            end
         end
         ST_DMUL: begin
            state_in = ST_DACC;
         end
         ST_DACC: begin
            acc_in = ((cidx_ff == 3'd0) ? 64'sd0 : acc_ff) + prod_sh[63:0];
            if (cidx_ff == 3'd2) begin
               dist_in[vi_ff] = acc_in - 64'(offs_ff);
               cidx_in        = 3'd0;
               vi_in          = vi_ff + 2'd1;
               state_in       = (vi_ff == 2'd2) ? ST_CLASS : ST_DMUL;
            end else begin
               cidx_in  = cidx_ff + 3'd1;
               state_in = ST_DMUL;
            end
         end
         ST_CLASS: begin
            for (int i = 0; i < 3; i++) begin
               ins_in[i] = !dist_ff[i][63];
            end
            xk_in   = 1'b0;
            slot_in = 3'd0;
            if (ins_in == 3'b000) begin
               state_in = ST_IDLE;
            end else if (ins_in == 3'b111) begin
               emit_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_DINIT;
            end
         end
         ST_DINIT: begin
            r_in     = dist_ff[s_idx];
            den_in   = dist_ff[s_idx] - dist_ff[e_idx];
            q_in     = '0;
            bc_in    = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring divide, one quotient bit a cycle
            if (r2 >= den_ff) begin
               r_in = r2 - den_ff;
               q_in = {q_ff[QW-2:0], 1'b1};
            end else begin
               r_in = r2;
               q_in = {q_ff[QW-2:0], 1'b0};
            end
            bc_in = bc_ff + 1'b1;
            if (bc_ff == BCW'(FRAC_BITS - 1)) begin
               cidx_in  = 3'd0;
               state_in = ST_IMUL;
            end
         end
         ST_IMUL: begin
            state_in = ST_IACC;
         end
         ST_IACC: begin
            if (isum > 35'sh0_7FFF_FFFF) begin
               cross_in[xk_ff][cidx_ff] = 32'sh7FFF_FFFF;
            end else if (isum < -35'sh0_8000_0000) begin
               cross_in[xk_ff][cidx_ff] = 32'sh8000_0000;
            end else begin
               cross_in[xk_ff][cidx_ff] = isum[31:0];
            end
            if (cidx_ff == 3'(COORDS - 1)) begin
               if (!xk_ff) begin
                  xk_in    = 1'b1;
                  state_in = ST_DINIT;
               end else begin
                  emit_in  = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               cidx_in  = cidx_ff + 3'd1;
               state_in = ST_IMUL;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= 2'd0;
         emit_ff    <= 1'b0;
         rv_ff      <= 1'b0;
         norm_ff[0] <= NORMAL_X_RST;
         norm_ff[1] <= NORMAL_Y_RST;
         norm_ff[2] <= NORMAL_Z_RST;
         offs_ff    <= OFFSET_RST;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         emit_ff  <= emit_in;
         rv_ff    <= rv_in;
         norm_ff  <= norm_in;
         offs_ff  <= offs_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff   <= held_in;
      colour_ff <= colour_in;
      vi_ff     <= vi_in;
      cidx_ff   <= cidx_in;
      acc_ff    <= acc_in;
      dist_ff   <= dist_in;
      prod_ff   <= prod_in;
      ins_ff    <= ins_in;
      xk_ff     <= xk_in;
      q_ff      <= q_in;
      r_ff      <= r_in;
      den_ff    <= den_in;
      bc_ff     <= bc_in;
      cross_ff  <= cross_in;
      slot_ff   <= slot_in;
      ov_ff     <= ov_in;
      otri_ff   <= otri_in;
      olast_ff  <= olast_in;
      ocol_ff   <= ocol_in;
   end

   assign req_stall          = (state_ff != ST_IDLE) || emit_ff;
   // plane registers stay fixed while a triangle is being classified and clipped
   assign csr_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rv_ff;
   assign rsp_out_x          = ov_ff[0];
   assign rsp_out_y          = ov_ff[1];
   assign rsp_out_z          = ov_ff[2];
   assign rsp_out_u          = ov_ff[3];
   assign rsp_out_v          = ov_ff[4];
   assign rsp_out_w          = ov_ff[5];
   assign rsp_out_colour     = ocol_ff;
   assign rsp_triangle_index = otri_ff;
   assign rsp_last           = olast_ff;

endmodule
